// ===== hdl/assert_macros.svh =====
// Assertion helpers for the interpolator core. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gbi_pkg.sv =====
// ----------------------------------------------------------------------------
// gbi_pkg
// Shared types and codes of the grid bilinear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package gbi_pkg;

    localparam int DW        = 32;  // Q12.20 data width
    localparam int QUO_BITS  = 41;  // quotient bits kept before saturation

    typedef logic signed [DW-1:0] data_t;
    typedef logic [1:0]           op_t;
    typedef logic                 cfg_idx_t;

    localparam op_t OP_WR_X    = 2'd0;
    localparam op_t OP_WR_Q    = 2'd1;
    localparam op_t OP_WR_GRID = 2'd2;
    localparam op_t OP_QUERY   = 2'd3;

    localparam cfg_idx_t CFG_X_USED = 1'b0;
    localparam cfg_idx_t CFG_Q_USED = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/gbi_in_if.sv =====
// ----------------------------------------------------------------------------
// gbi_in_if
// Input channel: write and query transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbi_in_if import gbi_pkg::*; ();
    logic        valid;
    logic        ready;
    op_t         operation;
    logic [6:0]  x_slot;
    logic [4:0]  q_slot;
    logic [1:0]  flavour;
    data_t       write_value;
    data_t       x_coord;
    data_t       q_coord;

    modport source (output valid, operation, x_slot, q_slot, flavour, write_value,
                    x_coord, q_coord, input ready);
    modport sink   (input valid, operation, x_slot, q_slot, flavour, write_value,
                    x_coord, q_coord, output ready);
endinterface

`default_nettype wire

// ===== hdl/gbi_out_if.sv =====
// ----------------------------------------------------------------------------
// gbi_out_if
// Output channel: one interpolated result per query.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbi_out_if import gbi_pkg::*; ();
    logic   valid;
    logic   ready;
    data_t  result;
    logic   divide_fault;

    modport source (output valid, result, divide_fault, input ready);
    modport sink   (input valid, result, divide_fault, output ready);
endinterface

`default_nettype wire

// ===== hdl/grid_bilinear_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_core
// Bilinear interpolation over a rectilinear grid held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries write transactions (x knot, q knot, grid value) and queries.
//   Writes go to memory in the cycle they are accepted and give no result.
//   A query gives one transaction on out_ch (result, divide_fault).
//   cfg_we/cfg_index/cfg_data set the used knot counts; write only when idle.
// A query runs two binary searches (x, then q) through the one-port knot
//   memory, fetches the four knots and four grid values, and then runs three
//   linear steps (two along x, one along q); each step may need a serial
//   division of one quotient bit per cycle over 41 bits. Writes leave the
//   sequencer idle, so in_ch stays ready for the next transaction.
// Only one query is in flight; in_ch stays ready while the last result
//   waits in the output register, and the next result stalls until out_ch
//   takes it. Reset clears control state and sets both knot counts to 2;
//   memories are not cleared and must be written before being read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module grid_bilinear_interpolator_core import gbi_pkg::*; #(
    parameter int MAX_X_KNOTS = 128,
    parameter int MAX_Q_KNOTS = 32,
    parameter int FLAVOURS    = 3
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire cfg_idx_t cfg_index,
    input  wire logic [7:0] cfg_data,
    gbi_in_if.sink        in_ch,
    gbi_out_if.source     out_ch
);

    localparam int XW     = (MAX_X_KNOTS > 1) ? $clog2(MAX_X_KNOTS) : 1;
    localparam int QW     = (MAX_Q_KNOTS > 1) ? $clog2(MAX_Q_KNOTS) : 1;
    localparam int KDEPTH = MAX_X_KNOTS + MAX_Q_KNOTS;
    localparam int KAW    = $clog2(KDEPTH);
    localparam int GDEPTH = MAX_X_KNOTS * MAX_Q_KNOTS * FLAVOURS;
    localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int NW     = 2 * DW;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SRD   = 4'd1;
    localparam logic [3:0] ST_SCMP  = 4'd2;
    localparam logic [3:0] ST_FETCH = 4'd3;
    localparam logic [3:0] ST_PREP  = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_CHK   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_NEXT  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    localparam data_t D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam data_t D_MIN = {1'b1, {(DW-1){1'b0}}};

    function automatic logic [GAW-1:0] grid_addr(input int xi, input int qi, input int f);
        grid_addr = GAW'((xi * MAX_Q_KNOTS + qi) * FLAVOURS + f);
    endfunction

    // configuration
    logic [7:0] x_used_reg;
    logic [5:0] q_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_used_reg <= 8'd2;
            q_used_reg <= 6'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_USED: x_used_reg <= cfg_data;
                CFG_Q_USED: q_used_reg <= cfg_data[5:0];
                default:    ;
            endcase
        end
    end

    int nx_int, nq_int;
    always_comb
    begin
        nx_int = (x_used_reg < 8'd2) ? 2 :
                 ((int'(x_used_reg) > MAX_X_KNOTS) ? MAX_X_KNOTS : int'(x_used_reg));
        nq_int = (q_used_reg < 6'd2) ? 2 :
                 ((int'(q_used_reg) > MAX_Q_KNOTS) ? MAX_Q_KNOTS : int'(q_used_reg));
    end

    // memories
    data_t knot_mem [KDEPTH];
    data_t grid_mem [GDEPTH];

    logic           k_we, g_we;
    logic [KAW-1:0] k_waddr, k_raddr;
    logic [GAW-1:0] g_waddr, g_raddr;
    data_t          k_rd_reg, g_rd_reg;

    always_ff @(posedge clk)
    begin
        if (k_we)
            knot_mem[k_waddr] <= in_ch.write_value;
        k_rd_reg <= knot_mem[k_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            grid_mem[g_waddr] <= in_ch.write_value;
        g_rd_reg <= grid_mem[g_raddr];
    end

    // control and datapath registers
    logic [3:0]          state_reg, state_next;
    logic                axis_reg, axis_next;
    logic [XW-1:0]       xlo_reg, xlo_next, xhi_reg, xhi_next;
    logic [QW-1:0]       qlo_reg, qlo_next, qhi_reg, qhi_next;
    data_t               xpos_reg, xpos_next, qpos_reg, qpos_next;
    logic [1:0]          flv_reg, flv_next;
    logic [2:0]          fcnt_reg, fcnt_next;
    data_t               kn_reg [4];
    data_t               kn_next [4];
    data_t               gv_reg [4];
    data_t               gv_next [4];
    logic [1:0]          step_reg, step_next;
    data_t               row0_reg, row0_next, row1_reg, row1_next;
    logic signed [DW:0]  dy_reg, dy_next, dp_reg, dp_next, dk_reg, dk_next;
    logic [NW-1:0]       num_reg, num_next;
    logic                neg_reg, neg_next;
    logic [DW-1:0]       dkmag_reg, dkmag_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [QUO_BITS-1:0] dq_reg, dq_next;
    logic [5:0]          dcnt_reg, dcnt_next;
    data_t               y1_reg, y1_next;
    logic                fault_reg, fault_next;
    data_t               res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    data_t               out_result_reg, out_result_next;
    logic                out_fault_reg, out_fault_next;

    logic                in_acc;
    int                  mid_x, mid_q;
    logic signed [DW:0]  magdy, magdp, magdk;
    logic [DW:0]         trial;
    logic signed [QUO_BITS:0] sum;

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign in_acc          = in_ch.valid && in_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.result   = out_result_reg;
    assign out_ch.divide_fault = out_fault_reg;

    always_comb
    begin
        mid_x = (int'(xlo_reg) + int'(xhi_reg)) >> 1;
        mid_q = (int'(qlo_reg) + int'(qhi_reg)) >> 1;
        magdy = dy_reg[DW] ? -dy_reg : dy_reg;
        magdp = dp_reg[DW] ? -dp_reg : dp_reg;
        magdk = dk_reg[DW] ? -dk_reg : dk_reg;
        trial = {rem_reg, dq_reg[QUO_BITS-1]};
        sum   = (QUO_BITS+1)'(y1_reg) +
                (neg_reg ? -(QUO_BITS+1)'(signed'({1'b0, dq_reg}))
                         :  (QUO_BITS+1)'(signed'({1'b0, dq_reg})));
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        xlo_next   = xlo_reg;
        xhi_next   = xhi_reg;
        qlo_next   = qlo_reg;
        qhi_next   = qhi_reg;
        xpos_next  = xpos_reg;
        qpos_next  = qpos_reg;
        flv_next   = flv_reg;
        fcnt_next  = fcnt_reg;
        kn_next    = kn_reg;
        gv_next    = gv_reg;
        step_next  = step_reg;
        row0_next  = row0_reg;
        row1_next  = row1_reg;
        dy_next    = dy_reg;
        dp_next    = dp_reg;
        dk_next    = dk_reg;
        num_next   = num_reg;
        neg_next   = neg_reg;
        dkmag_next = dkmag_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        dcnt_next  = dcnt_reg;
        y1_next    = y1_reg;
        fault_next = fault_reg;
        res_next   = res_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_result_next = out_result_reg;
        out_fault_next  = out_fault_reg;
        k_we    = 1'b0;
        g_we    = 1'b0;
        k_waddr = KAW'(int'(in_ch.x_slot));
        g_waddr = grid_addr(int'(in_ch.x_slot), int'(in_ch.q_slot), int'(in_ch.flavour));
        k_raddr = KAW'(mid_x);
        g_raddr = grid_addr(int'(xlo_reg), int'(qlo_reg), int'(flv_reg));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_ch.operation)
                        OP_WR_X:
                            k_we = (int'(in_ch.x_slot) < MAX_X_KNOTS);
                        OP_WR_Q:
                        begin
                            k_we    = (int'(in_ch.q_slot) < MAX_Q_KNOTS);
                            k_waddr = KAW'(MAX_X_KNOTS + int'(in_ch.q_slot));
                        end
                        OP_WR_GRID:
                            g_we = (int'(in_ch.x_slot) < MAX_X_KNOTS) &&
                                   (int'(in_ch.q_slot) < MAX_Q_KNOTS) &&
                                   (int'(in_ch.flavour) < FLAVOURS);
                        OP_QUERY:
                        begin
                            fault_next = 1'b0;
                            res_next   = '0;
                            xpos_next  = in_ch.x_coord;
                            qpos_next  = in_ch.q_coord;
                            flv_next   = in_ch.flavour;
                            axis_next  = 1'b0;
                            xlo_next   = '0;
                            xhi_next   = XW'(nx_int - 1);
                            qlo_next   = '0;
                            qhi_next   = QW'(nq_int - 1);
                            state_next = (int'(in_ch.flavour) < FLAVOURS) ? ST_SRD : ST_DONE;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SRD:
            begin
                if (!axis_reg)
                begin
                    k_raddr = KAW'(mid_x);
                    if (int'(xhi_reg) - int'(xlo_reg) > 1)
                        state_next = ST_SCMP;
                    else
                        axis_next = 1'b1;
                end
                else
                begin
                    k_raddr = KAW'(MAX_X_KNOTS + mid_q);
                    if (int'(qhi_reg) - int'(qlo_reg) > 1)
                        state_next = ST_SCMP;
                    else
                    begin
                        fcnt_next  = '0;
                        state_next = ST_FETCH;
                    end
                end
            end

            ST_SCMP:
            begin
                if (!axis_reg)
                begin
                    if (k_rd_reg > xpos_reg)
                        xhi_next = XW'(mid_x);
                    else
                        xlo_next = XW'(mid_x);
                end
                else
                begin
                    if (k_rd_reg > qpos_reg)
                        qhi_next = QW'(mid_q);
                    else
                        qlo_next = QW'(mid_q);
                end
                state_next = ST_SRD;
            end

            ST_FETCH:
            begin
                // knots: x0, x1, q0, q1; grid: (x0,q0) (x1,q0) (x0,q1) (x1,q1)
                if (!fcnt_reg[1])
                    k_raddr = KAW'(int'(xlo_reg) + int'(fcnt_reg[0]));
                else
                    k_raddr = KAW'(MAX_X_KNOTS + int'(qlo_reg) + int'(fcnt_reg[0]));
                g_raddr = grid_addr(int'(xlo_reg) + int'(fcnt_reg[0]),
                                    int'(qlo_reg) + int'(fcnt_reg[1]), int'(flv_reg));
                if (fcnt_reg != 3'd0)
                begin
                    kn_next[2'(fcnt_reg - 3'd1)] = k_rd_reg;
                    gv_next[2'(fcnt_reg - 3'd1)] = g_rd_reg;
                end
                fcnt_next = fcnt_reg + 3'd1;
                if (fcnt_reg == 3'd4)
                begin
                    step_next  = 2'd0;
                    state_next = ST_PREP;
                end
            end

            ST_PREP:
            begin
                priority case (step_reg)
                    2'd0:
                    begin
                        y1_next = gv_reg[0];
                        dy_next = (DW+1)'(gv_reg[1]) - (DW+1)'(gv_reg[0]);
                    end
                    2'd1:
                    begin
                        y1_next = gv_reg[2];
                        dy_next = (DW+1)'(gv_reg[3]) - (DW+1)'(gv_reg[2]);
                    end
                    default:
                    begin
                        y1_next = row0_reg;
                        dy_next = (DW+1)'(row1_reg) - (DW+1)'(row0_reg);
                    end
                endcase
                if (step_reg == 2'd2)
                begin
                    dp_next = (DW+1)'(qpos_reg) - (DW+1)'(kn_reg[2]);
                    dk_next = (DW+1)'(kn_reg[3]) - (DW+1)'(kn_reg[2]);
                end
                else
                begin
                    dp_next = (DW+1)'(xpos_reg) - (DW+1)'(kn_reg[0]);
                    dk_next = (DW+1)'(kn_reg[1]) - (DW+1)'(kn_reg[0]);
                end
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                num_next   = NW'(magdy[DW-1:0]) * NW'(magdp[DW-1:0]);
                neg_next   = dy_reg[DW] ^ dp_reg[DW];
                dkmag_next = magdk[DW-1:0];
                state_next = ST_CHK;
            end

            ST_CHK:
            begin
                state_next = ST_NEXT;
                if (dk_reg == '0)
                begin
                    fault_next = 1'b1;
                    res_next   = (num_reg == '0) ? y1_reg : (neg_reg ? D_MIN : D_MAX);
                end
                else if (num_reg == '0)
                    res_next = y1_reg;
                else if (NW'(num_reg[NW-1:QUO_BITS]) >= NW'(dkmag_reg))
                    // quotient reaches 2^41: saturate without dividing
                    res_next = (neg_reg ^ dk_reg[DW]) ? D_MIN : D_MAX;
                else
                begin
                    neg_next   = neg_reg ^ dk_reg[DW];
                    rem_next   = DW'(num_reg[NW-1:QUO_BITS]);
                    dq_next    = num_reg[QUO_BITS-1:0];
                    dcnt_next  = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (trial >= {1'b0, dkmag_reg})
                begin
                    rem_next = DW'(trial - {1'b0, dkmag_reg});
                    dq_next  = {dq_reg[QUO_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DW-1:0];
                    dq_next  = {dq_reg[QUO_BITS-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'(QUO_BITS - 1))
                    state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (dq_reg > {1'b1, {(QUO_BITS-1){1'b0}}})
                    res_next = neg_reg ? D_MIN : D_MAX;
                else if (sum > (QUO_BITS+1)'(D_MAX))
                    res_next = D_MAX;
                else if (sum < (QUO_BITS+1)'(D_MIN))
                    res_next = D_MIN;
                else
                    res_next = sum[DW-1:0];
                state_next = ST_NEXT;
            end

            ST_NEXT:
            begin
                priority case (step_reg)
                    2'd0:
                    begin
                        row0_next  = res_reg;
                        step_next  = 2'd1;
                        state_next = ST_PREP;
                    end
                    2'd1:
                    begin
                        row1_next  = res_reg;
                        step_next  = 2'd2;
                        state_next = ST_PREP;
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_result_next = res_reg;
                    out_fault_next  = fault_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg       <= axis_next;
        xlo_reg        <= xlo_next;
        xhi_reg        <= xhi_next;
        qlo_reg        <= qlo_next;
        qhi_reg        <= qhi_next;
        xpos_reg       <= xpos_next;
        qpos_reg       <= qpos_next;
        flv_reg        <= flv_next;
        fcnt_reg       <= fcnt_next;
        kn_reg         <= kn_next;
        gv_reg         <= gv_next;
        step_reg       <= step_next;
        row0_reg       <= row0_next;
        row1_reg       <= row1_next;
        dy_reg         <= dy_next;
        dp_reg         <= dp_next;
        dk_reg         <= dk_next;
        num_reg        <= num_next;
        neg_reg        <= neg_next;
        dkmag_reg      <= dkmag_next;
        rem_reg        <= rem_next;
        dq_reg         <= dq_next;
        dcnt_reg       <= dcnt_next;
        y1_reg         <= y1_next;
        fault_reg      <= fault_next;
        res_reg        <= res_next;
        out_result_reg <= out_result_next;
        out_fault_reg  <= out_fault_next;
    end

    `ASSERT_IMP(a_search_span, (state_reg == ST_SCMP) && !axis_reg, (int'(xhi_reg) - int'(xlo_reg)) > 1, "x search compare with collapsed span")
    `ASSERT_NXT(a_query_leaves_idle, in_acc && (in_ch.operation == OP_QUERY), state_reg != ST_IDLE, "query accepted but sequencer stayed idle")
    `ASSERT_IMP(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == ST_DONE, "result raised outside the done state")
    `ASSERT_IMP(a_div_count, state_reg == ST_DIV, dcnt_reg < 6'(QUO_BITS), "divider ran past its last quotient bit")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_bilinear_interpolator_core: loads knots and
// grid, runs directed and random write/query traffic under several knot-count
// settings with random stalls, and checks every result against a predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import gbi_pkg::*;

    localparam int NX = 128;
    localparam int NQ = 32;
    localparam int NF = 3;
    localparam int LAT = 200;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    typedef struct {
        op_t        op;
        logic [6:0] xs;
        logic [4:0] qs;
        logic [1:0] fl;
        data_t      wv;
        data_t      xc;
        data_t      qc;
    } item_t;

    class interp_scoreboard;
        longint     x_knots[NX];
        longint     q_knots[NQ];
        longint     grid[NX][NQ][NF];
        bit [7:0]   x_used_reg;
        bit [5:0]   q_used_reg;
        data_t      exp_result[$];
        bit         exp_fault[$];
        int         errors;
        int         n_queries;
        int         n_writes;
        int         n_faults;

        function new();
            x_used_reg = 2;
            q_used_reg = 2;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [7:0] v);
            if (idx == CFG_X_USED)
                x_used_reg = v;
            else
                q_used_reg = v[5:0];
        endfunction

        function int x_count();
            return (x_used_reg < 2) ? 2 : (x_used_reg > NX) ? NX : x_used_reg;
        endfunction

        function int q_count();
            return (q_used_reg < 2) ? 2 : (q_used_reg > NQ) ? NQ : q_used_reg;
        endfunction

        function int pending();
            return exp_result.size();
        endfunction

        function int lower_knot(bit on_x, int n, longint pos);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = n - 1;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if ((on_x ? x_knots[mid] : q_knots[mid]) > pos)
                    hi = mid;
                else
                    lo = mid;
            end
            return lo;
        endfunction

        function longint unsigned mag(longint d);
            return (d < 0) ? longint'(-d) : d;
        endfunction

        // one linear step with truncating divide and saturation
        function longint lerp(longint pos, longint k1, longint k2,
                              longint y1, longint y2, inout bit fault);
            longint dy;
            longint dp;
            longint dk;
            longint unsigned num;
            longint unsigned quo;
            longint s;
            bit neg;
            dy = y2 - y1;
            dp = pos - k1;
            dk = k2 - k1;
            num = mag(dy) * mag(dp);
            neg = (dy < 0) != (dp < 0);
            if (dk == 0) begin
                fault = 1'b1;
                if (num == 0) return y1;
                return neg ? VMIN : VMAX;
            end
            if (num == 0) return y1;
            if (dk < 0) neg = !neg;
            quo = num / mag(dk);
            if (quo > (64'd1 << 40)) return neg ? VMIN : VMAX;
            s = neg ? -longint'(quo) : longint'(quo);
            s = y1 + s;
            return (s > VMAX) ? VMAX : (s < VMIN) ? VMIN : s;
        endfunction

        function void note_input(item_t it);
            int x0;
            int q0;
            int f;
            bit fault;
            longint row0;
            longint row1;
            longint r;
            case (it.op)
                OP_WR_X:    x_knots[it.xs] = longint'(it.wv);
                OP_WR_Q:    q_knots[it.qs] = longint'(it.wv);
                OP_WR_GRID: if (it.fl < NF) grid[it.xs][it.qs][it.fl] = longint'(it.wv);
                default:
                begin
                    n_queries++;
                    if (it.fl >= NF) begin
                        exp_result.push_back('0);
                        exp_fault.push_back(1'b0);
                    end else begin
                        f = it.fl;
                        fault = 1'b0;
                        x0 = lower_knot(1'b1, x_count(), longint'(it.xc));
                        q0 = lower_knot(1'b0, q_count(), longint'(it.qc));
                        row0 = lerp(longint'(it.xc), x_knots[x0], x_knots[x0+1],
                                    grid[x0][q0][f], grid[x0+1][q0][f], fault);
                        row1 = lerp(longint'(it.xc), x_knots[x0], x_knots[x0+1],
                                    grid[x0][q0+1][f], grid[x0+1][q0+1][f], fault);
                        r = lerp(longint'(it.qc), q_knots[q0], q_knots[q0+1],
                                 row0, row1, fault);
                        exp_result.push_back(data_t'(r));
                        exp_fault.push_back(fault);
                    end
                end
            endcase
            if (it.op != OP_QUERY) n_writes++;
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(data_t r, logic f);
            data_t er;
            bit ef;
            if (exp_result.size() == 0) begin
                report($sformatf("unexpected result %h fault %b", r, f));
                return;
            end
            er = exp_result.pop_front();
            ef = exp_fault.pop_front();
            if (f === 1'b1) n_faults++;
            if (r !== er) report($sformatf("result %h, expected %h", r, er));
            if (f !== ef) report($sformatf("divide_fault %b, expected %b", f, ef));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_idx_t   cfg_index;
    logic [7:0] cfg_data;

    gbi_in_if  in_ch();
    gbi_out_if out_ch();

    grid_bilinear_interpolator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    interp_scoreboard sb = new();
    bit no_gaps = 1'b0;
    bit hold_start = 1'b0;
    int hold_left = 0;
    int n_settings = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_input('{in_ch.operation, in_ch.x_slot, in_ch.q_slot, in_ch.flavour,
                            in_ch.write_value, in_ch.x_coord, in_ch.q_coord});
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.result, out_ch.divide_fault);
    end

    // result sink: random stalls plus one long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start) begin
                hold_left = 600;
                hold_start = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= no_gaps || ($urandom_range(99) >= 11);
            end
        end
    end

    function automatic data_t x_base(int i);
        return data_t'((longint'(i) - 64) * 64'sd16777216);
    endfunction

    function automatic data_t q_base(int i);
        return data_t'((longint'(i) - 16) * 64'sd67108864);
    endfunction

    function automatic data_t grid_value();
        int r;
        r = $urandom_range(99);
        if (r < 70) return data_t'(longint'($urandom_range(33554431)) - 16777216);
        if (r < 90) return data_t'($urandom);
        return r[0] ? data_t'(VMAX) : data_t'(VMIN);
    endfunction

    function automatic item_t rand_fields();
        item_t it;
        it.op = op_t'($urandom_range(3));
        it.xs = $urandom;
        it.qs = $urandom;
        it.fl = $urandom;
        it.wv = $urandom;
        it.xc = $urandom;
        it.qc = $urandom;
        return it;
    endfunction

    function automatic item_t make_query(logic [1:0] fl, data_t xc, data_t qc);
        item_t it;
        it = rand_fields();
        it.op = OP_QUERY;
        it.fl = fl;
        it.xc = xc;
        it.qc = qc;
        return it;
    endfunction

    function automatic item_t make_write(op_t op, int xs, int qs, int fl, data_t wv);
        item_t it;
        it = rand_fields();
        it.op = op;
        it.xs = xs;
        it.qs = qs;
        it.fl = fl;
        it.wv = wv;
        return it;
    endfunction

    function automatic data_t pick_coord(bit on_x);
        int r;
        int k;
        r = $urandom_range(99);
        if (r < 15) return $urandom;
        if (on_x) begin
            k = $urandom_range(sb.x_count() - 1);
            if (r < 30) return data_t'(sb.x_knots[k]);
            return data_t'(longint'(x_base(k)) + longint'($urandom_range(33554431))
                           - 16777216);
        end
        k = $urandom_range(sb.q_count() - 1);
        if (r < 30) return data_t'(sb.q_knots[k]);
        return data_t'(longint'(q_base(k)) + longint'($urandom_range(134217727)) - 67108864);
    endfunction

    function automatic item_t make_random_item();
        item_t it;
        int r;
        int k;
        r = $urandom_range(99);
        it = rand_fields();
        if (r < 55) begin
            it.op = OP_QUERY;
            it.fl = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
            it.xc = pick_coord(1'b1);
            it.qc = pick_coord(1'b0);
        end else if (r < 72) begin
            it.op = OP_WR_GRID;
            it.fl = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
            it.wv = grid_value();
        end else if (r < 90) begin
            // knot rewrite: mostly in order, sometimes a duplicate or a wild value
            it.op = r[0] ? OP_WR_X : OP_WR_Q;
            k = (it.op == OP_WR_X) ? it.xs : it.qs;
            if ($urandom_range(9) < 7)
                it.wv = data_t'(longint'((it.op == OP_WR_X) ? x_base(k) : q_base(k))
                                + longint'($urandom_range(4194303)));
            else if (k > 0 && $urandom_range(1))
                it.wv = data_t'((it.op == OP_WR_X) ? sb.x_knots[k-1] : sb.q_knots[k-1]);
        end
        return it;
    endfunction

    task automatic send(item_t it);
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= it.op;
        in_ch.x_slot      <= it.xs;
        in_ch.q_slot      <= it.qs;
        in_ch.flavour     <= it.fl;
        in_ch.write_value <= it.wv;
        in_ch.x_coord     <= it.xc;
        in_ch.q_coord     <= it.qc;
        do @(posedge clk); while (!in_ch.ready);
        if (!no_gaps && $urandom_range(99) < 11) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (LAT) @(posedge clk);
    endtask

    task automatic set_counts(logic [7:0] xv, logic [7:0] qv);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_X_USED;
        cfg_data  <= xv;
        @(posedge clk);
        sb.set_reg(CFG_X_USED, xv);
        cfg_index <= CFG_Q_USED;
        cfg_data  <= qv;
        @(posedge clk);
        sb.set_reg(CFG_Q_USED, qv);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic load_knots();
        for (int i = 0; i < NX; i++)
            send(make_write(OP_WR_X, i, $urandom, $urandom, x_base(i)));
        for (int i = 0; i < NQ; i++)
            send(make_write(OP_WR_Q, $urandom, i, $urandom, q_base(i)));
    endtask

    logic [7:0] x_setting[7] = '{8'd128, 8'd0, 8'd5, 8'd255, 8'd64, 8'd2, 8'd100};
    logic [7:0] q_setting[7] = '{8'd32, 8'd1, 8'd3, 8'd63, 8'd17, 8'd2, 8'd40};

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_X_USED;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_WR_X;
        in_ch.x_slot      = '0;
        in_ch.q_slot      = '0;
        in_ch.flavour     = '0;
        in_ch.write_value = '0;
        in_ch.x_coord     = '0;
        in_ch.q_coord     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every store entry gets written before anything reads it
        no_gaps = 1'b1;
        load_knots();
        for (int x = 0; x < NX; x++)
            for (int q = 0; q < NQ; q++)
                for (int f = 0; f < NF; f++)
                    send(make_write(OP_WR_GRID, x, q, f,
                         data_t'(longint'($urandom_range(33554431)) - 16777216)));
        no_gaps = 1'b0;

        // directed: reset counts, extremes, flavours, equal and unsorted knots
        send(make_query(2'd0, data_t'(VMIN), data_t'(VMIN)));
        send(make_query(2'd1, data_t'(VMAX), data_t'(VMAX)));
        send(make_query(2'd2, x_base(1), q_base(0)));
        send(make_query(2'd3, data_t'(VMAX), data_t'(VMIN)));
        send(make_write(OP_WR_GRID, 0, 0, 3, data_t'(VMAX)));
        send(make_write(OP_WR_GRID, 1, 1, 0, data_t'(VMAX)));
        send(make_write(OP_WR_GRID, 0, 0, 0, data_t'(VMIN)));
        send(make_query(2'd0, data_t'(VMAX), data_t'(VMAX)));
        send(make_query(2'd0, data_t'(VMIN), q_base(1)));
        send(make_write(OP_WR_X, 1, 0, 0, x_base(0)));
        send(make_query(2'd0, x_base(0), q_base(0)));
        send(make_query(2'd0, data_t'(VMAX), q_base(1)));
        send(make_write(OP_WR_X, 1, 0, 0, x_base(1)));
        send(make_write(OP_WR_Q, 0, 1, 0, q_base(0)));
        send(make_query(2'd1, x_base(0), data_t'(VMIN)));
        send(make_write(OP_WR_Q, 0, 1, 0, q_base(1)));
        send(make_write(OP_WR_X, 0, 0, 0, data_t'(VMAX)));
        send(make_query(2'd2, 32'sd0, 32'sd0));
        send(make_write(OP_WR_X, 0, 0, 0, x_base(0)));
        send(make_write(OP_WR_GRID, 1, 1, 0, 32'sd1048576));
        send(make_write(OP_WR_GRID, 0, 0, 0, -32'sd1048576));
        send(make_query(2'd0, x_base(0), q_base(0)));
        drain();

        for (int p = 0; p < 7; p++)
        begin
            set_counts(x_setting[p], q_setting[p]);
            load_knots();
            no_gaps = (p == 1);
            for (int i = 0; i < 145; i++)
            begin
                if (p == 3 && i == 40) hold_start = 1'b1;
                send(make_random_item());
            end
            no_gaps = 1'b0;
            drain();
        end

        $display("%0d writes and %0d queries over %0d knot-count settings",
                 sb.n_writes, sb.n_queries, n_settings);
        $display("%0d results flagged divide_fault, %0d mismatches",
                 sb.n_faults, sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/gbi_pkg.sv
hdl/gbi_in_if.sv
hdl/gbi_out_if.sv
hdl/grid_bilinear_interpolator_core.sv
sim/tb.sv
